// File: rtl/core/acpu_pkg.sv
// Shared types, constants and instruction decode for the accumulator CPU execute block.
// No dependencies; every other file of the block imports this package.

package acpu_pkg;

    // Machine word and data memory geometry (memory depth must be a power of two)
    localparam int WORD_W    = 16;
    localparam int MEM_WORDS = 65536;
    localparam int ADDR_W    = $clog2(MEM_WORDS);

    // Reset value of the program length register
    localparam logic [WORD_W-1:0] PROG_LEN_RST = 16'hFFFF;

    // Instruction bit positions
    localparam int BIT_COMPUTE = 15;
    localparam int BIT_SIMACT  = 14;
    localparam int BIT_USEMEM  = 12;
    localparam int BIT_DEST_A  = 10;
    localparam int BIT_DEST_D  = 9;
    localparam int BIT_DEST_M  = 8;
    localparam int BIT_ARITH   = 7;
    localparam int BIT_OP1     = 6;
    localparam int BIT_OP0     = 5;
    localparam int BIT_ZX      = 4;
    localparam int BIT_SW      = 3;
    localparam int BIT_LT      = 2;
    localparam int BIT_EQ      = 1;
    localparam int BIT_GT      = 0;
    localparam int BIT_STOP    = 0;

    // Operation select (bit6:bit5); logic meaning when arith is clear
    typedef enum logic [1:0] {
        LOP_AND = 2'd0,
        LOP_OR  = 2'd1,
        LOP_XOR = 2'd2,
        LOP_NOT = 2'd3
    } t_logic_op;

    // Decoded ALU / branch controls
    typedef struct packed {
        logic      use_mem;
        logic      swap;
        logic      zero_x;
        logic      arith;
        t_logic_op op;
        logic      jmp_gt;
        logic      jmp_eq;
        logic      jmp_lt;
    } t_alu_ctrl;

    // Data memory write request
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] data;
    } t_mem_wr;

    function automatic t_alu_ctrl decode_alu(input logic [WORD_W-1:0] ins);
        t_alu_ctrl c;
        c.use_mem = ins[BIT_USEMEM];
        c.swap    = ins[BIT_SW];
        c.zero_x  = ins[BIT_ZX];
        c.arith   = ins[BIT_ARITH];
        c.op      = t_logic_op'({ins[BIT_OP1], ins[BIT_OP0]});
        c.jmp_gt  = ins[BIT_GT];
        c.jmp_eq  = ins[BIT_EQ];
        c.jmp_lt  = ins[BIT_LT];
        return c;
    endfunction

endpackage

// File: rtl/core/accumulator_cpu_execute.sv
// Top level of the accumulator CPU execute block: registers, pipeline control, output stage.
// Depends on acpu_pkg, acpu_alu and acpu_dmem.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_instruction) carries one instruction word
//   per transfer, the word at the PC last reported on o_next_pc (0 after reset).
//   Output channel (o_out_valid / i_out_ready) returns one result per instruction:
//   next PC, A, D, ALU result, jump flag and halted flag, in instruction order.
//   i_cfg_we / i_cfg_wdata write the program length; write it only while idle.
//   The data memory is read at address A on the input transfer; the instruction and its
//   read data enter the execute stage, and its result is registered into the output stage.
//   Throughput: one instruction per cycle while results are taken. The read address for the
//   next instruction is the A just produced by the executing one, and a same-address memory
//   write is forwarded, so dependent instructions do not stall.
//   Reset (synchronous, active low) clears A, D, PC, the halt flag and the output stage,
//   then a zero-fill sweep clears every word of the data memory with o_in_ready low;
//   configuration writes are taken during the sweep.
//   Receiver stall: a held result blocks the executing instruction, which in turn holds
//   o_in_ready low; nothing is dropped.

module accumulator_cpu_execute (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [acpu_pkg::WORD_W-1:0] i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [acpu_pkg::WORD_W-1:0] i_instruction,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [acpu_pkg::WORD_W-1:0] o_next_pc,
    output logic [acpu_pkg::WORD_W-1:0] o_reg_a_out,
    output logic [acpu_pkg::WORD_W-1:0] o_reg_d_out,
    output logic [acpu_pkg::WORD_W-1:0] o_alu_result,
    output logic                        o_jump_taken,
    output logic                        o_halted
);
    import acpu_pkg::*;

    // Architectural state
    logic [WORD_W-1:0] r_prog_len;
    logic [WORD_W-1:0] r_a;
    logic [WORD_W-1:0] r_d;
    logic [WORD_W-1:0] r_pc;
    logic              r_stopped;

    // Execute stage
    logic              r_ex_vld;
    logic [WORD_W-1:0] r_ex_ins;

    // Output stage
    logic              r_out_vld;
    logic [WORD_W-1:0] r_out_pc;
    logic [WORD_W-1:0] r_out_a;
    logic [WORD_W-1:0] r_out_d;
    logic [WORD_W-1:0] r_out_res;
    logic              r_out_jump;
    logic              r_out_halt;

    // Execute results
    logic [WORD_W-1:0] n_a;
    logic [WORD_W-1:0] n_d;
    logic [WORD_W-1:0] n_pc;
    logic [WORD_W-1:0] n_res;
    logic              n_jump;
    logic              n_stopped;
    logic              mem_we;

    logic              in_fire;
    logic              ex_fire;
    logic              clr_busy;
    logic [WORD_W-1:0] mem_q;
    logic [WORD_W-1:0] alu_res;
    logic              alu_jump;
    logic [WORD_W-1:0] pc_inc;
    logic [WORD_W-1:0] rd_a;
    t_alu_ctrl         alu_ctrl;
    t_mem_wr           mem_wr;

    // Handshake
    assign ex_fire    = r_ex_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !clr_busy && (!r_ex_vld || ex_fire);
    assign in_fire    = i_in_valid && o_in_ready;

    // ALU
    assign alu_ctrl = decode_alu(r_ex_ins);

    acpu_alu u_alu (
        .i_ctrl   (alu_ctrl),
        .i_reg_d  (r_d),
        .i_reg_a  (r_a),
        .i_mem    (mem_q),
        .o_result (alu_res),
        .o_jump   (alu_jump)
    );

    // Instruction execute
    assign pc_inc = r_pc + WORD_W'(1);

    always_comb begin
        n_a       = r_a;
        n_d       = r_d;
        n_pc      = r_pc;
        n_res     = '0;
        n_jump    = 1'b0;
        n_stopped = 1'b1;
        mem_we    = 1'b0;
        if (!r_stopped && (r_pc < r_prog_len)) begin
            n_stopped = 1'b0;
            if (!r_ex_ins[BIT_COMPUTE]) begin
                n_a  = r_ex_ins;
                n_pc = pc_inc;
            end else if (r_ex_ins[BIT_SIMACT]) begin
                if (r_ex_ins[BIT_STOP]) begin
                    n_stopped = 1'b1;
                end else begin
                    n_pc = pc_inc;
                end
            end else begin
                n_res  = alu_res;
                mem_we = r_ex_ins[BIT_DEST_M];
                if (r_ex_ins[BIT_DEST_A]) begin
                    n_a = alu_res;
                end
                if (r_ex_ins[BIT_DEST_D]) begin
                    n_d = alu_res;
                end
                n_jump = alu_jump;
                n_pc   = alu_jump ? n_a : pc_inc;
            end
            if (n_pc >= r_prog_len) begin
                n_stopped = 1'b1;
            end
        end
    end

    // Data memory: write at old A, read for the next instruction at the new A
    assign mem_wr.we   = ex_fire && mem_we;
    assign mem_wr.addr = r_a[ADDR_W-1:0];
    assign mem_wr.data = alu_res;
    assign rd_a        = ex_fire ? n_a : r_a;

    acpu_dmem u_dmem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (mem_wr),
        .i_rd_en    (in_fire),
        .i_rd_addr  (rd_a[ADDR_W-1:0]),
        .o_rd_data  (mem_q),
        .o_clr_busy (clr_busy)
    );

    // Program length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog_len <= PROG_LEN_RST;
        end else if (i_cfg_we) begin
            r_prog_len <= i_cfg_wdata;
        end
    end

    // Architectural state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a       <= '0;
            r_d       <= '0;
            r_pc      <= '0;
            r_stopped <= 1'b0;
        end else if (ex_fire) begin
            r_a       <= n_a;
            r_d       <= n_d;
            r_pc      <= n_pc;
            r_stopped <= n_stopped;
        end
    end

    // Execute stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex_vld <= 1'b0;
        end else if (in_fire) begin
            r_ex_vld <= 1'b1;
        end else if (ex_fire) begin
            r_ex_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_ex_ins <= i_instruction;
        end
    end

    // Output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (ex_fire) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ex_fire) begin
            r_out_pc   <= n_pc;
            r_out_a    <= n_a;
            r_out_d    <= n_d;
            r_out_res  <= n_res;
            r_out_jump <= n_jump;
            r_out_halt <= n_stopped;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_next_pc    = r_out_pc;
    assign o_reg_a_out  = r_out_a;
    assign o_reg_d_out  = r_out_d;
    assign o_alu_result = r_out_res;
    assign o_jump_taken = r_out_jump;
    assign o_halted     = r_out_halt;

endmodule

// File: rtl/core/acpu_alu.sv
// ALU and branch condition evaluation of the accumulator CPU.
// Depends on acpu_pkg for the decoded control struct.

module acpu_alu (
    input  acpu_pkg::t_alu_ctrl         i_ctrl,
    input  logic [acpu_pkg::WORD_W-1:0] i_reg_d,
    input  logic [acpu_pkg::WORD_W-1:0] i_reg_a,
    input  logic [acpu_pkg::WORD_W-1:0] i_mem,
    output logic [acpu_pkg::WORD_W-1:0] o_result,
    output logic                        o_jump
);
    import acpu_pkg::*;

    logic [WORD_W-1:0] x0;
    logic [WORD_W-1:0] y0;
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] y_ar;
    logic              neg;
    logic              zero;

    // Operand select, swap, zero X
    always_comb begin
        x0   = i_reg_d;
        y0   = i_ctrl.use_mem ? i_mem : i_reg_a;
        x    = i_ctrl.swap ? y0 : x0;
        y    = i_ctrl.swap ? x0 : y0;
        if (i_ctrl.zero_x) begin
            x = '0;
        end
        y_ar = i_ctrl.op[0] ? WORD_W'(1) : y;
    end

    // Arithmetic or logic result
    always_comb begin
        o_result = '0;
        if (i_ctrl.arith) begin
            o_result = i_ctrl.op[1] ? (x - y_ar) : (x + y_ar);
        end else begin
            unique case (i_ctrl.op)
                LOP_AND: o_result = x & y;
                LOP_OR:  o_result = x | y;
                LOP_XOR: o_result = x ^ y;
                LOP_NOT: o_result = ~x;
                default: o_result = '0;
            endcase
        end
    end

    // Signed tests of the result
    assign neg    = o_result[WORD_W-1];
    assign zero   = (o_result == '0);
    assign o_jump = (i_ctrl.jmp_gt && !zero && !neg)
                 || (i_ctrl.jmp_eq && zero)
                 || (i_ctrl.jmp_lt && neg);

endmodule

// File: rtl/core/acpu_dmem.sv
// Data memory of the accumulator CPU: one write port, one registered read port,
// write-to-read forwarding and a zero-fill sweep after reset. Depends on acpu_pkg.

module acpu_dmem (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  acpu_pkg::t_mem_wr           i_wr,
    input  logic                        i_rd_en,
    input  logic [acpu_pkg::ADDR_W-1:0] i_rd_addr,
    output logic [acpu_pkg::WORD_W-1:0] o_rd_data,
    output logic                        o_clr_busy
);
    import acpu_pkg::*;

    logic [WORD_W-1:0] mem [MEM_WORDS];

    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [WORD_W-1:0] r_q;
    logic              r_fwd_vld;
    logic [WORD_W-1:0] r_fwd_data;
    t_mem_wr           wr;

    // Clear sweep owns the write port until it finishes
    always_comb begin
        if (r_clr_busy) begin
            wr.we   = 1'b1;
            wr.addr = r_clr_addr;
            wr.data = '0;
        end else begin
            wr = i_wr;
        end
    end

    // Clear sweep control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == ADDR_W'(MEM_WORDS - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end
    end

    // Write port
    always_ff @(posedge i_clk) begin
        if (wr.we) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Read port, returns old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q <= mem[i_rd_addr];
        end
    end

    // Forward a write that lands on the address being read in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_vld <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd_vld <= wr.we && (wr.addr == i_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_data <= wr.data;
        end
    end

    assign o_rd_data  = r_fwd_vld ? r_fwd_data : r_q;
    assign o_clr_busy = r_clr_busy;

endmodule

// File: rtl/core/acpu_checker.sv
// Port-level assertions for the accumulator CPU execute block, bound to the top level.
// Depends on acpu_pkg and accumulator_cpu_execute.

module acpu_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        o_in_ready,
    input  logic                        o_out_valid,
    input  logic                        i_out_ready,
    input  logic [acpu_pkg::WORD_W-1:0] o_next_pc,
    input  logic [acpu_pkg::WORD_W-1:0] o_reg_a_out,
    input  logic [acpu_pkg::WORD_W-1:0] o_reg_d_out,
    input  logic [acpu_pkg::WORD_W-1:0] o_alu_result,
    input  logic                        o_jump_taken,
    input  logic                        o_halted
);
    import acpu_pkg::*;

    logic              out_xfer;
    logic              r_seen_halt;
    logic [WORD_W-1:0] r_last_pc;

    assign out_xfer = o_out_valid && i_out_ready;

    // Track the halt state and PC as seen on the output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_halt <= 1'b0;
        end else if (out_xfer && o_halted) begin
            r_seen_halt <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_xfer) begin
            r_last_pc <= o_next_pc;
        end
    end

    // Reset empties the output stage and blocks input during the memory sweep
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_ready))
        else $error("output valid or input ready right after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_next_pc) && $stable(o_reg_a_out)
             && $stable(o_reg_d_out) && $stable(o_alu_result)
             && $stable(o_jump_taken) && $stable(o_halted)))
        else $error("stalled result changed");

    // A taken jump lands on the new A
    a_jump_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_jump_taken) |-> (o_next_pc == o_reg_a_out))
        else $error("jump target differs from A");

    // Once halted, the machine stays put
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && r_seen_halt) |->
            (o_halted && !o_jump_taken && (o_alu_result == '0)
             && (o_next_pc == r_last_pc)))
        else $error("halted machine made progress");

endmodule

bind accumulator_cpu_execute acpu_checker u_acpu_checker (.*);
